// ----- rtl/sfc_pkg.sv -----
// Shared types and constants for the sphere/frustum cull core.
// No dependencies.
`timescale 1ns / 1ps
package sfc_pkg;
    localparam int FRAC_BITS_DEF = 16;
    typedef enum logic [1:0] {
        KIND_LOAD_PROJ = 2'd0,
        KIND_LOAD_MV   = 2'd1,
        KIND_TEST      = 2'd2,
        KIND_NONE      = 2'd3
    } kind_t;
    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;
endpackage

// ----- rtl/sfc_isqrt.sv -----
// Bit-serial integer square root, one result bit per cycle.
// Depends on nothing.
`timescale 1ns / 1ps
module sfc_isqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [65:0] radicand,
    output logic        done,
    output logic [32:0] root
);
    logic [65:0] rem_reg, rem_next;
    logic [32:0] root_reg, root_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [67:0] cand;

    always_comb begin
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        cand      = '0;
        if (start) begin
            rem_next  = radicand;
            root_next = '0;
            cnt_next  = 6'd33;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // restoring root: try bit (cnt-1), trial is root*2^(j+1) + 2^(2j)
            cand = (68'(root_reg) << cnt_reg) + (68'd1 << {cnt_reg - 6'd1, 1'b0});
            if ({2'b00, rem_reg} >= cand) begin
                rem_next  = 66'({2'b00, rem_reg} - cand);
                root_next = root_reg | (33'd1 << (cnt_reg - 6'd1));
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) busy_next = 1'b0;
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end
    assign done = busy_reg && (cnt_reg == 6'd1);
    assign root = root_next;
endmodule

// ----- rtl/sphere_frustum_cull_core.sv -----
// Sphere against view-frustum cull core, one shared multiply-accumulate unit.
// A load writes its entry and goes straight to the output handshake; a test forms the 16
// clip entries (4 products + 1 saturate each), then per plane a dot product, the squared
// norm, its root and a compare, skipping zero-normal planes and stopping at a rejecting one.
// One word in flight at a time; a result is held in the output register until taken.
// aresetn (synchronous, active low) clears both matrices and the control state.
`timescale 1ns / 1ps
module sphere_frustum_cull_core #(
    parameter int FRAC_BITS = sfc_pkg::FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: entry_index[3:0], entry_value[35:4], pos_x[67:36], pos_y[99:68],
    //        pos_z[131:100], sphere_radius[162:132], zero fill to 168
    input  logic [167:0] s_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: inside_res[0], zero fill to 8
    output logic [7:0]   m_tdata,
    // tuser: is_test[0]
    output logic         m_tuser
);
    import sfc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MM, ST_MM_SAT, ST_PL, ST_DOT, ST_DIST, ST_NRM, ST_ROOT,
        ST_THR, ST_CMP, ST_OUT
    } state_t;

    state_t state_reg;
    logic signed [31:0] proj_reg [16];
    logic signed [31:0] mv_reg   [16];
    logic signed [31:0] clip_reg [16];
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic [30:0] rad_reg;
    logic signed [31:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic [3:0]  ent_reg;     // clip entry
    logic [1:0]  k_reg;       // term within a dot
    logic [2:0]  pl_reg;      // plane
    logic signed [67:0] acc_reg;   // exact sum of products
    logic [65:0] n2_reg;
    logic        inside_reg, is_test_reg;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod_reg;
    logic        prod_v_reg;
    logic        rt_start, rt_done;
    logic [32:0] rt_root;
    logic [65:0] rt_radicand;
    logic [63:0] thr_prod_reg;

    // the last square is still in prod_reg when the root starts
    assign rt_radicand = n2_reg + 66'(unsigned'(prod_reg));

    sfc_isqrt u_isqrt (
        .aclk(aclk), .aresetn(aresetn), .start(rt_start),
        .radicand(rt_radicand), .done(rt_done), .root(rt_root)
    );

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        if (v > 68'(SAT_MAX)) return SAT_MAX;
        if (v < 68'(SAT_MIN)) return SAT_MIN;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] sel_comp(input logic signed [31:0] m,
                                                    input logic signed [31:0] s,
                                                    input logic minus);
        logic signed [32:0] t;
        t = minus ? (33'(m) - 33'(s)) : (33'(m) + 33'(s));
        return sat32(68'(t));
    endfunction

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MM: begin
                mul_a = mv_reg[{ent_reg[3:2], k_reg}];
                mul_b = proj_reg[{k_reg, ent_reg[1:0]}];
            end
            ST_DOT: begin
                case (k_reg)
                    2'd0: begin mul_a = pa_reg; mul_b = px_reg; end
                    2'd1: begin mul_a = pb_reg; mul_b = py_reg; end
                    default: begin mul_a = pc_reg; mul_b = pz_reg; end
                endcase
            end
            ST_NRM: begin
                case (k_reg)
                    2'd0: begin mul_a = pa_reg; mul_b = pa_reg; end
                    2'd1: begin mul_a = pb_reg; mul_b = pb_reg; end
                    default: begin mul_a = pc_reg; mul_b = pc_reg; end
                endcase
            end
            default: ;
        endcase
    end

    logic [1:0] axis;
    logic signed [67:0] dist_full;
    logic signed [67:0] thr_s;
    assign axis      = pl_reg[2:1];
    assign dist_full = (acc_reg >>> FRAC_BITS) + 68'(pd_reg);
    assign thr_s     = 68'({4'd0, thr_prod_reg >> FRAC_BITS});
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_OUT);
    assign m_tdata   = {7'd0, inside_reg};
    assign m_tuser   = is_test_reg;
    assign rt_start  = (state_reg == ST_NRM) && prod_v_reg && (k_reg == 2'd3);

    always_ff @(posedge aclk) begin
        prod_reg     <= 64'(mul_a) * 64'(mul_b);
        thr_prod_reg <= {33'd0, rad_reg} * {31'd0, rt_root};
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            prod_v_reg <= 1'b0;
            for (int i = 0; i < 16; i++) begin
                proj_reg[i] <= '0;
                mv_reg[i]   <= '0;
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        case (kind_t'(s_tuser))
                            KIND_LOAD_PROJ: proj_reg[s_tdata[3:0]] <= s_tdata[35:4];
                            KIND_LOAD_MV:   mv_reg[s_tdata[3:0]]   <= s_tdata[35:4];
                            default: ;
                        endcase
                        if (kind_t'(s_tuser) == KIND_TEST) begin
                            px_reg <= s_tdata[67:36];
                            py_reg <= s_tdata[99:68];
                            pz_reg <= s_tdata[131:100];
                            rad_reg <= s_tdata[162:132];
                            is_test_reg <= 1'b1;
                            inside_reg <= 1'b1;
                            ent_reg <= '0;
                            k_reg <= '0;
                            acc_reg <= '0;
                            prod_v_reg <= 1'b0;
                            state_reg <= ST_MM;
                        end else begin
                            is_test_reg <= 1'b0;
                            inside_reg  <= 1'b0;
                            state_reg   <= ST_OUT;
                        end
                    end
                end
                ST_MM: begin
                    // multiply issues while k counts; each product accumulates the cycle after it issues
                    prod_v_reg <= (k_reg != 2'd3) || !prod_v_reg || 1'b1;
                    if (prod_v_reg) acc_reg <= acc_reg + 68'(prod_reg);
                    k_reg <= k_reg + 2'd1;
                    if (k_reg == 2'd3) begin
                        state_reg <= ST_MM_SAT;
                    end
                end
                ST_MM_SAT: begin
                    clip_reg[ent_reg] <= sat32((acc_reg + 68'(prod_reg)) >>> FRAC_BITS);
                    acc_reg    <= '0;
                    prod_v_reg <= 1'b0;
                    k_reg      <= '0;
                    ent_reg    <= ent_reg + 4'd1;
                    if (ent_reg == 4'd15) begin
                        pl_reg    <= '0;
                        state_reg <= ST_PL;
                    end else begin
                        state_reg <= ST_MM;
                    end
                end
                ST_PL: begin
                    if (pl_reg == 3'd6) begin
                        state_reg <= ST_OUT;
                    end else begin
                        pa_reg <= sel_comp(clip_reg[3],  clip_reg[{2'd0, axis}], pl_reg[0]);
                        pb_reg <= sel_comp(clip_reg[7],  clip_reg[{2'd1, axis}], pl_reg[0]);
                        pc_reg <= sel_comp(clip_reg[11], clip_reg[{2'd2, axis}], pl_reg[0]);
                        pd_reg <= sel_comp(clip_reg[15], clip_reg[{2'd3, axis}], pl_reg[0]);
                        acc_reg <= '0;
                        k_reg <= '0;
                        prod_v_reg <= 1'b0;
                        state_reg <= ST_DOT;
                    end
                end
                ST_DOT: begin
                    if (pa_reg == 0 && pb_reg == 0 && pc_reg == 0) begin
                        pl_reg    <= pl_reg + 3'd1;
                        state_reg <= ST_PL;
                    end else begin
                        if (prod_v_reg) acc_reg <= acc_reg + 68'(prod_reg);
                        prod_v_reg <= 1'b1;
                        k_reg <= k_reg + 2'd1;
                        if (k_reg == 2'd3) state_reg <= ST_DIST;
                    end
                end
                ST_DIST: begin
                    acc_reg     <= dist_full;
                    k_reg       <= '0;
                    n2_reg      <= '0;
                    prod_v_reg  <= 1'b0;
                    state_reg   <= ST_NRM;
                end
                ST_NRM: begin
                    if (prod_v_reg) n2_reg <= n2_reg + 66'(unsigned'(prod_reg));
                    prod_v_reg <= 1'b1;
                    k_reg <= k_reg + 2'd1;
                    if (k_reg == 2'd3) state_reg <= ST_ROOT;
                end
                ST_ROOT: begin
                    if (rt_done) state_reg <= ST_THR;
                end
                ST_THR: state_reg <= ST_CMP;
                ST_CMP: begin
                    if (acc_reg < -thr_s) begin
                        inside_reg <= 1'b0;
                        state_reg  <= ST_OUT;
                    end else begin
                        pl_reg    <= pl_reg + 3'd1;
                        state_reg <= ST_PL;
                    end
                end
                ST_OUT: begin
                    if (m_tready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_load_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> !m_tdata[0]) else $error("load ack with inside set");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for sphere_frustum_cull_core: matrix loads and sphere tests.
// Holds its own fixed-point cull predictor; depends on sfc_pkg and the core.
`timescale 1ns / 1ps
module testbench;
    import sfc_pkg::*;

    localparam int FB = FRAC_BITS_DEF;

    typedef struct packed {
        logic is_test;
        logic inside_res;
    } verdict_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [167:0] s_tdata = '0;
    logic [1:0]   s_tuser = KIND_NONE;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [7:0]   m_tdata;
    logic         m_tuser;

    logic signed [31:0] proj_mat [16];
    logic signed [31:0] mv_mat [16];
    verdict_t           verdict_q [$];
    int                 mismatches = 0;
    bit                 sink_free = 1'b0;  // no random stall
    bit                 sink_hold = 1'b0;  // long hold-off

    sphere_frustum_cull_core u_dut (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return SAT_MAX;
        if (v < -66'sd2147483648) return SAT_MIN;
        return v[31:0];
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] n);
        logic [63:0] rem, root, bit_v;
        rem = n;
        root = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > rem) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (rem >= root + bit_v) begin
                rem = rem - (root + bit_v);
                root = (root >> 1) + bit_v;
            end else begin
                root = root >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return root;
    endfunction

    function automatic logic sphere_visible(input logic signed [31:0] x, y, z,
                                            input logic [30:0] r);
        logic signed [31:0]  clip [16];
        logic signed [95:0]  acc;
        logic signed [31:0]  a, b, c, d;
        logic signed [95:0]  plane_dist;
        logic [63:0]         n2;
        logic [127:0]        thr;
        int                  ax;
        for (int row = 0; row < 4; row++)
            for (int col = 0; col < 4; col++) begin
                acc = 0;
                for (int k = 0; k < 4; k++)
                    acc += 96'(mv_mat[row*4+k]) * 96'(proj_mat[k*4+col]);
                clip[row*4+col] = sat32(66'(acc >>> FB));
            end
        for (int p = 0; p < 6; p++) begin
            ax = p >> 1;
            if (p & 1) begin
                a = sat32(66'(clip[3])  - 66'(clip[ax]));
                b = sat32(66'(clip[7])  - 66'(clip[4+ax]));
                c = sat32(66'(clip[11]) - 66'(clip[8+ax]));
                d = sat32(66'(clip[15]) - 66'(clip[12+ax]));
            end else begin
                a = sat32(66'(clip[3])  + 66'(clip[ax]));
                b = sat32(66'(clip[7])  + 66'(clip[4+ax]));
                c = sat32(66'(clip[11]) + 66'(clip[8+ax]));
                d = sat32(66'(clip[15]) + 66'(clip[12+ax]));
            end
            if (a == 0 && b == 0 && c == 0) continue;
            plane_dist = ((96'(a) * 96'(x) + 96'(b) * 96'(y) + 96'(c) * 96'(z)) >>> FB)
                         + 96'(d);
            // each square fits 63 bits; wrap to 64 as unsigned sum
            n2 = 64'(96'(a) * 96'(a)) + 64'(96'(b) * 96'(b)) + 64'(96'(c) * 96'(c));
            thr = (128'(r) * 128'(root64(n2))) >> FB;
            if (plane_dist < -$signed({1'b0, thr[94:0]})) return 1'b0;
        end
        return 1'b1;
    endfunction

    // drive one word, predict its verdict, wait for acceptance
    task automatic send_word(input kind_t kind, input logic [3:0] idx,
                             input logic [31:0] val, input logic [31:0] x, y, z,
                             input logic [30:0] r, input bit may_idle = 1'b1);
        verdict_t v;
        while (may_idle && $urandom_range(99) < 23) @(posedge aclk);
        v = '0;
        case (kind)
            KIND_LOAD_PROJ: proj_mat[idx] = val;
            KIND_LOAD_MV:   mv_mat[idx] = val;
            KIND_TEST: begin
                v.is_test = 1'b1;
                v.inside_res = sphere_visible(x, y, z, r);
            end
            default: ;
        endcase
        verdict_q.push_back(v);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {5'd0, r, z, y, x, val, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        s_tvalid <= 1'b0;
        // the core is busy for at least this cycle after taking a word
        @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_q(input int span);
        logic [31:0] v;
        case ($urandom_range(5))
            0: v = $urandom();
            1: v = 32'h7FFF_FFFF;
            2: v = 32'h8000_0000;
            default: v = $signed(32'($urandom_range(2*span))) - span;
        endcase
        return v;
    endfunction

    task automatic load_matrix(input kind_t kind, input int span, input bit ident);
        for (int i = 0; i < 16; i++)
            send_word(kind, 4'(i),
                      ident ? ((i % 5 == 0) ? 32'h0001_0000 : 32'h0)
                            : ($urandom_range(3) == 0 ? rand_q(span)
                               : $signed(32'($urandom_range(2*span))) - span),
                      $urandom(), $urandom(), $urandom(), 31'($urandom()));
    endtask

    task automatic send_sphere(input int span);
        logic [31:0] rr;
        rr = $urandom_range(3) == 0 ? $urandom() : $urandom_range(span);
        send_word(KIND_TEST, 4'($urandom()), $urandom(),
                  $signed(32'($urandom_range(2*span))) - span,
                  $signed(32'($urandom_range(2*span))) - span,
                  $urandom_range(7) == 0 ? $urandom()
                      : $signed(32'($urandom_range(2*span))) - span,
                  31'(rr));
    endtask

    task automatic drain_results;
        while (verdict_q.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed;
        // all-zero matrices: every plane has a zero normal
        send_word(KIND_TEST, 4'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 31'h0);
        send_word(KIND_NONE, 4'hF, 32'hFFFF_FFFF, '1, '1, '1, '1);
        load_matrix(KIND_LOAD_PROJ, 0, 1'b1);
        load_matrix(KIND_LOAD_MV, 0, 1'b1);
        send_word(KIND_TEST, 4'h0, 32'h0, 32'h0, 32'h0, 32'h0, 31'h0);
        send_word(KIND_TEST, 4'h0, 32'h0, 32'h0008_0000, 32'h0, 32'h0, 31'h0001_0000);
        send_word(KIND_TEST, 4'h0, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  31'h7FFF_FFFF);
        send_word(KIND_TEST, 4'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h0);
        // saturating clip entries
        send_word(KIND_LOAD_PROJ, 4'h3, 32'h7FFF_FFFF, 0, 0, 0, 0);
        send_word(KIND_LOAD_MV, 4'hC, 32'h8000_0000, 0, 0, 0, 0);
        send_word(KIND_TEST, 4'h0, 32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 31'h100);
        drain_results();
    endtask

    task automatic test_random(input int rounds);
        int span;
        for (int n = 0; n < rounds; n++) begin
            span = $urandom_range(3) == 0 ? 32'h7FFF_FFFF : (1 << $urandom_range(12, 20));
            if ($urandom_range(4) == 0) load_matrix(KIND_LOAD_PROJ, span, 1'b0);
            if ($urandom_range(4) == 0) load_matrix(KIND_LOAD_MV, span, 1'b0);
            repeat ($urandom_range(2)) begin
                send_word(kind_t'($urandom_range(1)), 4'($urandom()), rand_q(span),
                          $urandom(), $urandom(), $urandom(), 31'($urandom()));
            end
            if ($urandom_range(30) == 0)
                send_word(KIND_NONE, 4'($urandom()), $urandom(), $urandom(),
                          $urandom(), $urandom(), 31'($urandom()));
            repeat ($urandom_range(1, 4)) send_sphere(span);
        end
    endtask

    task automatic test_backpressure;
        sink_hold = 1'b1;
        fork
            repeat (4) send_sphere(1 << 18);
            begin
                for (int c = 0; c < 1500; c++) @(posedge aclk);
                sink_hold = 1'b0;
            end
        join
        drain_results();
    endtask

    task automatic test_steady;
        sink_free = 1'b1;
        repeat (30) send_word(KIND_TEST, 4'h0, 32'h0, $urandom(), $urandom(),
                              $urandom(), 31'($urandom()), 1'b0);
        drain_results();
        sink_free = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (!aresetn || sink_hold) m_tready <= 1'b0;
        else m_tready <= sink_free || ($urandom_range(99) >= 23);
    end

    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: is_test %0b inside %0b", m_tuser, m_tdata[0]);
            end else begin
                want = verdict_q.pop_front();
                if (want.is_test !== m_tuser || want.inside_res !== m_tdata[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected is_test %0b inside %0b, got %0b %0b",
                                 want.is_test, want.inside_res, m_tuser, m_tdata[0]);
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < 16; i++) begin
            proj_mat[i] = 0;
            mv_mat[i] = 0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_random(55);
        test_steady();
        test_random(55);
        drain_results();
        repeat (600) @(posedge aclk);
        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
